// ----- hdl/asgr_pkg.sv -----
// -----------------------------------------------------------------------------
// asgr_pkg
// Shared types and constants of the ANSI SGR escape parser: parser state,
// result items and the byte codes that the decoder recognizes.
// -----------------------------------------------------------------------------
package asgr_pkg;

   // Parser modes, one-hot.
   typedef enum logic [2:0] {
      MODE_TEXT   = 3'b001,
      MODE_ESCAPE = 3'b010,
      MODE_CSI    = 3'b100
   } mode_type;

   // Result kinds.
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_FG   = 2'd1;
   localparam logic [1:0] KIND_BG   = 2'd2;

   // Byte codes.
   localparam logic [7:0] BYTE_ESC     = 8'd27;
   localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
   localparam logic [7:0] BYTE_SEMI    = 8'h3B;
   localparam logic [7:0] BYTE_M       = 8'h6D;
   localparam logic [7:0] BYTE_DIGIT_0 = 8'h30;
   localparam logic [7:0] BYTE_DIGIT_9 = 8'h39;
   localparam logic [7:0] FINAL_LO     = 8'd64;
   localparam logic [7:0] FINAL_HI     = 8'd126;

   // SGR values that select a palette color.
   localparam logic [15:0] CMD_FG      = 16'd38;
   localparam logic [15:0] CMD_BG      = 16'd48;
   localparam logic [15:0] COLOR_INDEX = 16'd5;
   localparam logic [15:0] FIELD_SAT   = 16'hFFFF;

   localparam logic [1:0] LAST_FIELD = 2'd3;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  field_index;
      logic        field_has_content;
      logic        digits_stopped;
      logic [15:0] command_value;
      logic [15:0] colour_type_value;
      logic [7:0]  palette_value;
      logic        sequence_nonempty;
   } parse_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } rsp_item_type;

   // Results caused by one input byte: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } out_batch_type;

endpackage

// ----- hdl/ansi_sgr_escape_parser.sv -----
// -----------------------------------------------------------------------------
// ansi_sgr_escape_parser
// Terminal byte stream parser that passes text through and turns
// ESC [ 38;5;n m and ESC [ 48;5;n m into palette color commands.
// -----------------------------------------------------------------------------
// Usage:
// Raw bytes enter on the req_ stream, one byte per item in req_tdata. Each
// byte yields zero, one or two result items on the rsp_ stream: rsp_tdata
// carries a character code or palette index, rsp_tuser says which (character,
// foreground, background), and rsp_tlast marks the last item caused by a byte.
// A byte is decoded in the cycle it is accepted and its results are written
// to a four-entry output queue that drives rsp_. The block takes one byte
// per cycle while req_tready is high; a byte that produces two results
// (ESC followed by anything but '[') queues both, and rsp_ shows them in
// turn. req_tready is low while the queue holds three or more items, which
// is what a stalled receiver causes: nothing is dropped.
// csr_wr_en writes csr_wr_data to the decode enable; with it low every byte
// passes through as a character. Write it only while the block is idle.
// Reset brings the parser to text mode, empties the queue and sets the
// decode enable to one.
// -----------------------------------------------------------------------------
module ansi_sgr_escape_parser (
   input  logic       clock,
   input  logic       reset,
   // Input byte stream.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   // Result stream.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] value
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast,   // last result of its input byte
   // Decode enable register.
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   asgr_pkg::parse_state_type state_ff, state_in;
   asgr_pkg::out_batch_type   batch;
   asgr_pkg::rsp_item_type    out_item;
   logic                      enable_ff, enable_in;
   logic                      accept;

   assign accept    = req_tvalid && req_tready;
   assign enable_in = csr_wr_en ? csr_wr_data : enable_ff;

   // The parser state advances only on an accepted byte; the decoder sees
   // the stored state and the byte on the port in the same cycle.
   asgr_decode u_decode (
      .enable    (enable_ff),
      .data_byte (req_tdata),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .batch     (batch)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         state_ff  <= '{mode: asgr_pkg::MODE_TEXT, default: '0};
      end else begin
         enable_ff <= enable_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   // Results of the accepted byte are queued so the input keeps flowing
   // while the receiver holds off.
   asgr_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .batch     (batch),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.value;
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule

// ----- hdl/asgr_decode.sv -----
// -----------------------------------------------------------------------------
// asgr_decode
// Next-state and result logic for one input byte of the escape parser.
// -----------------------------------------------------------------------------
module asgr_decode (
   input  logic                     enable,
   input  logic [7:0]               data_byte,
   input  asgr_pkg::parse_state_type state_cur,
   output asgr_pkg::parse_state_type state_nxt,
   output asgr_pkg::out_batch_type   batch
);

   logic [3:0]  digit;
   logic [19:0] cmd_acc;
   logic [19:0] col_acc;
   logic [11:0] pal_acc;
   logic        three_fields;

   assign digit   = 4'(data_byte - asgr_pkg::BYTE_DIGIT_0);
   assign cmd_acc = ({4'd0, state_cur.command_value} << 3)
                  + ({4'd0, state_cur.command_value} << 1) + {16'd0, digit};
   assign col_acc = ({4'd0, state_cur.colour_type_value} << 3)
                  + ({4'd0, state_cur.colour_type_value} << 1) + {16'd0, digit};
   assign pal_acc = ({4'd0, state_cur.palette_value} << 3)
                  + ({4'd0, state_cur.palette_value} << 1) + {8'd0, digit};

   // The palette field counts once it has content or a later ';' closed it.
   assign three_fields = (state_cur.field_index == asgr_pkg::LAST_FIELD)
                      || (state_cur.field_index == 2'd2 && state_cur.field_has_content);

   always_comb begin
      state_nxt   = state_cur;
      batch.count = 2'd0;
      batch.item0 = '{kind: asgr_pkg::KIND_CHAR, value: data_byte, last: 1'b1};
      batch.item1 = '{kind: asgr_pkg::KIND_CHAR, value: data_byte, last: 1'b1};

      if (!enable) begin
         state_nxt.mode = asgr_pkg::MODE_TEXT;
         batch.count    = 2'd1;
      end else begin
         case (state_cur.mode)
            asgr_pkg::MODE_ESCAPE: begin
               if (data_byte == asgr_pkg::BYTE_LBRACK) begin
                  state_nxt.mode              = asgr_pkg::MODE_CSI;
                  state_nxt.field_index       = 2'd0;
                  state_nxt.field_has_content = 1'b0;
                  state_nxt.digits_stopped    = 1'b0;
                  state_nxt.command_value     = 16'd0;
                  state_nxt.colour_type_value = 16'd0;
                  state_nxt.palette_value     = 8'd0;
                  state_nxt.sequence_nonempty = 1'b0;
               end else begin
                  state_nxt.mode = asgr_pkg::MODE_TEXT;
                  batch.count    = 2'd2;
                  batch.item0    = '{kind: asgr_pkg::KIND_CHAR,
                                     value: asgr_pkg::BYTE_ESC, last: 1'b0};
               end
            end
            asgr_pkg::MODE_CSI: begin
               if (data_byte inside {[asgr_pkg::FINAL_LO:asgr_pkg::FINAL_HI]}) begin
                  state_nxt.mode = asgr_pkg::MODE_TEXT;
                  if (data_byte == asgr_pkg::BYTE_M && state_cur.sequence_nonempty
                      && three_fields
                      && state_cur.colour_type_value == asgr_pkg::COLOR_INDEX) begin
                     if (state_cur.command_value == asgr_pkg::CMD_FG) begin
                        batch.count = 2'd1;
                        batch.item0 = '{kind: asgr_pkg::KIND_FG,
                                        value: state_cur.palette_value, last: 1'b1};
                     end else if (state_cur.command_value == asgr_pkg::CMD_BG) begin
                        batch.count = 2'd1;
                        batch.item0 = '{kind: asgr_pkg::KIND_BG,
                                        value: state_cur.palette_value, last: 1'b1};
                     end
                  end
               end else begin
                  state_nxt.sequence_nonempty = 1'b1;
                  if (data_byte == asgr_pkg::BYTE_SEMI) begin
                     if (state_cur.field_index != asgr_pkg::LAST_FIELD) begin
                        state_nxt.field_index = state_cur.field_index + 2'd1;
                     end
                     state_nxt.field_has_content = 1'b0;
                     state_nxt.digits_stopped    = 1'b0;
                  end else begin
                     state_nxt.field_has_content = 1'b1;
                     if (!state_cur.digits_stopped) begin
                        if (data_byte inside
                            {[asgr_pkg::BYTE_DIGIT_0:asgr_pkg::BYTE_DIGIT_9]}) begin
                           case (state_cur.field_index)
                              2'd0: begin
                                 state_nxt.command_value = (cmd_acc > 20'(asgr_pkg::FIELD_SAT))
                                    ? asgr_pkg::FIELD_SAT : cmd_acc[15:0];
                              end
                              2'd1: begin
                                 state_nxt.colour_type_value =
                                    (col_acc > 20'(asgr_pkg::FIELD_SAT))
                                    ? asgr_pkg::FIELD_SAT : col_acc[15:0];
                              end
                              2'd2: begin
                                 state_nxt.palette_value = pal_acc[7:0];
                              end
                              default: begin
                              end
                           endcase
                        end else begin
                           state_nxt.digits_stopped = 1'b1;
                        end
                     end
                  end
               end
            end
            default: begin
               if (data_byte == asgr_pkg::BYTE_ESC) begin
                  state_nxt.mode = asgr_pkg::MODE_ESCAPE;
               end else begin
                  state_nxt.mode = asgr_pkg::MODE_TEXT;
                  batch.count    = 2'd1;
               end
            end
         endcase
      end
   end

endmodule

// ----- hdl/asgr_out_queue.sv -----
// -----------------------------------------------------------------------------
// asgr_out_queue
// Four-entry result queue that takes up to two items per cycle and hands
// out one per cycle while out_ready is high.
// -----------------------------------------------------------------------------
module asgr_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  asgr_pkg::out_batch_type batch,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output asgr_pkg::rsp_item_type  out_item
);

   asgr_pkg::rsp_item_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] push_num;
   logic       pop;

   assign push_num  = push ? batch.count : 2'd0;
   assign out_valid = (count_ff != 3'd0);
   assign pop       = out_valid && out_ready;
   // Room for a full two-item batch.
   assign room      = (count_ff <= 3'd2);
   assign out_item  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + push_num;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_num} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= batch.item0;
      end
      if (push_num == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= batch.item1;
      end
   end

endmodule

// ----- hdl/asgr_checker.sv -----
// -----------------------------------------------------------------------------
// asgr_checker
// Port-level checks of the ANSI SGR escape parser, bound to the top level.
// -----------------------------------------------------------------------------
module asgr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // The output queue is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Only the echoed ESC of a broken escape is followed by another result.
   a_nonlast_is_esc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tuser == asgr_pkg::KIND_CHAR && rsp_tdata == asgr_pkg::BYTE_ESC)
      else $error("non-last result is not an ESC character");

   // Palette commands are always the only result of their byte.
   a_palette_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != asgr_pkg::KIND_CHAR |-> rsp_tlast)
      else $error("palette command without last");

   // Both results of a byte are queued together, so the second is ready at once.
   a_pair_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second result of a byte missing");

endmodule

bind ansi_sgr_escape_parser asgr_checker u_asgr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .rsp_tlast   (rsp_tlast)
);

// ----- tb/tb_ansi_sgr_escape_parser.sv -----
// -----------------------------------------------------------------------------
// tb_ansi_sgr_escape_parser
// Self-checking testbench for the ANSI SGR escape parser. Terminal bytes are
// streamed into the block with random bursts and gaps while the result side
// stalls on its own pattern. A behavioral parser inside the testbench
// predicts every character and palette command, and each result item is
// compared field by field against the oldest prediction. Directed sequences
// cover the corner cases. Random traffic is mostly well-formed SGR sequences
// with random content, mixed with noise and broken sequences. It runs with
// decoding both on and off.
// -----------------------------------------------------------------------------
module tb_ansi_sgr_escape_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import asgr_pkg::*;

   // Clock, reset and every block input start at known values.
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'd0;    // [7:0] data_byte
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;             // [7:0] value
   logic [1:0] rsp_tuser;             // [1:0] kind
   logic       rsp_tlast;             // last result of its input byte
   logic       csr_wr_en   = 1'b0;
   logic       csr_wr_data = 1'b0;

   ansi_sgr_escape_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the run. The slowest legal run is far below this.
   initial begin
      #3_000_000;
      $display("Timeout: the run did not complete.");
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Parser shadow state. It mirrors the block's state and the decode enable
   // so that each accepted byte can be turned into the results it must cause.
   // ---------------------------------------------------------------------
   logic        decode_en     = 1'b1;
   mode_type    pmode         = MODE_TEXT;
   logic [1:0]  field_idx     = 2'd0;
   logic        field_content = 1'b0;
   logic        digits_stop   = 1'b0;
   logic [15:0] cmd_val       = 16'd0;
   logic [15:0] ctype_val     = 16'd0;
   logic [7:0]  pal_val       = 8'd0;
   logic        seq_nonempty  = 1'b0;

   // Results still owed by the block, oldest first.
   rsp_item_type pending_results[$];

   // Bytes of the chunk that is being assembled for the block.
   logic [7:0] seq_bytes[$];

   int bytes_sent      = 0;
   int results_checked = 0;
   int palette_cmds    = 0;
   int cfg_writes      = 0;
   int error_count     = 0;
   int burst_left      = 0;
   bit steady_sender   = 1'b0;

   task automatic expect_result(input logic [1:0] kind, input logic [7:0] value,
                                input logic last);
      rsp_item_type item;
      item.kind  = kind;
      item.value = value;
      item.last  = last;
      pending_results = {pending_results, item};
   endtask

   // Adds one byte at the end of the chunk under assembly.
   task automatic append_byte(input logic [7:0] b);
      seq_bytes = {seq_bytes, b};
   endtask

   // Appends one decimal digit to a field and clamps the field at its maximum.
   function automatic logic [15:0] sat_append(input logic [15:0] v, input int d);
      int n;
      n = v * 10 + d;
      return (n > FIELD_SAT) ? FIELD_SAT : n[15:0];
   endfunction

   // Advances the shadow parser by one accepted byte and records the results
   // that the byte causes.
   task automatic predict_byte(input logic [7:0] b);
      logic three_fields;
      int   digit;
      if (!decode_en) begin
         // Decoding off drops any partial sequence and passes the byte on.
         pmode = MODE_TEXT;
         expect_result(KIND_CHAR, b, 1'b1);
         return;
      end
      case (pmode)
         MODE_ESCAPE: begin
            if (b == BYTE_LBRACK) begin
               pmode         = MODE_CSI;
               field_idx     = 2'd0;
               field_content = 1'b0;
               digits_stop   = 1'b0;
               cmd_val       = 16'd0;
               ctype_val     = 16'd0;
               pal_val       = 8'd0;
               seq_nonempty  = 1'b0;
            end else begin
               // A lone ESC is flushed out together with the byte after it.
               pmode = MODE_TEXT;
               expect_result(KIND_CHAR, BYTE_ESC, 1'b0);
               expect_result(KIND_CHAR, b, 1'b1);
            end
         end
         MODE_CSI: begin
            if (b >= FINAL_LO && b <= FINAL_HI) begin
               pmode = MODE_TEXT;
               // The palette field counts if it has content or if a later
               // separator has closed it.
               three_fields = (field_idx == LAST_FIELD) ||
                              (field_idx == 2'd2 && field_content);
               if (b == BYTE_M && seq_nonempty && three_fields &&
                   ctype_val == COLOR_INDEX) begin
                  if (cmd_val == CMD_FG)
                     expect_result(KIND_FG, pal_val, 1'b1);
                  else if (cmd_val == CMD_BG)
                     expect_result(KIND_BG, pal_val, 1'b1);
               end
            end else begin
               seq_nonempty = 1'b1;
               if (b == BYTE_SEMI) begin
                  if (field_idx != LAST_FIELD)
                     field_idx = field_idx + 2'd1;
                  field_content = 1'b0;
                  digits_stop   = 1'b0;
               end else begin
                  field_content = 1'b1;
                  if (!digits_stop) begin
                     if (b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9) begin
                        digit = b - BYTE_DIGIT_0;
                        case (field_idx)
                           2'd0:    cmd_val   = sat_append(cmd_val, digit);
                           2'd1:    ctype_val = sat_append(ctype_val, digit);
                           2'd2:    pal_val   = 8'(pal_val * 10 + digit);
                           default: ;
                        endcase
                     end else begin
                        // Any non-digit ends the number of this field.
                        digits_stop = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            if (b == BYTE_ESC)
               pmode = MODE_ESCAPE;
            else
               expect_result(KIND_CHAR, b, 1'b1);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Input side. Bytes go out in bursts of random length; between bursts
   // the valid is often dropped for a random pause unless the sender runs steady.
   // The valid stays high from one item to the next inside a burst.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!steady_sender && $urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   task automatic send_queued_bytes();
      while (seq_bytes.size() != 0)
         send_byte(seq_bytes.pop_front());
   endtask

   // Holds the input idle until every owed result has come out, then waits on
   // for any byte that is still being decoded.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_decode_enable(input logic value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      decode_en = value;
      csr_wr_en <= 1'b0;
      cfg_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Random content helpers.
   // ---------------------------------------------------------------------

   // A parameter byte that is neither a digit, a separator nor a final byte.
   // ESC is favored because it must be collected like any other byte.
   function automatic logic [7:0] param_junk();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0)
         return BYTE_ESC;
      do
         c = 8'($urandom_range(0, 255));
      while ((c >= FINAL_LO && c <= FINAL_HI) || c == BYTE_SEMI ||
             (c >= BYTE_DIGIT_0 && c <= BYTE_DIGIT_9));
      return c;
   endfunction

   // Decimal digits of v, sometimes with leading zeros.
   task automatic queue_number(input int unsigned v);
      logic [7:0] digs[$];
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) append_byte(BYTE_DIGIT_0);
      do begin
         digs.push_front(8'(BYTE_DIGIT_0 + v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digs[i])
         append_byte(digs[i]);
   endtask

   // One parameter field: a junk prefix makes it read as zero, and a junk
   // suffix stops the number so that later digits are ignored.
   task automatic queue_field(input int unsigned v);
      if ($urandom_range(0, 15) == 0)
         append_byte(param_junk());
      queue_number(v);
      if ($urandom_range(0, 9) == 0) begin
         append_byte(param_junk());
         if ($urandom_range(0, 1) == 1)
            queue_number($urandom_range(0, 99));
      end
   endtask

   // ---------------------------------------------------------------------
   // Test tasks.
   // ---------------------------------------------------------------------

   // Byte extremes as text, a lone ESC before a plain byte, and ESC ESC.
   task automatic test_text_and_escapes();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(BYTE_ESC);
      send_text("A");
      send_byte(BYTE_ESC);
      send_byte(BYTE_ESC);
   endtask

   // Foreground with a palette value that wraps, and background with an
   // empty palette field closed by a separator.
   task automatic test_palette_commands();
      send_byte(BYTE_ESC);
      send_text("[38;5;300m");
      send_byte(BYTE_ESC);
      send_text("[48;5;;m");
   endtask

   // Turning decoding off in the middle of a sequence drops the sequence, and
   // turning it back on resumes in text mode.
   task automatic test_decode_disable();
      send_byte(BYTE_ESC);
      send_text("[38");
      write_decode_enable(1'b0);
      send_text("x");
      send_byte(BYTE_ESC);
      send_text("[");
      write_decode_enable(1'b1);
      send_text("5m");
   endtask

   // Mostly well-formed SGR sequences with random fields, the rest noise.
   task automatic test_mixed_traffic(input int target);
      int unsigned cmd;
      int unsigned ctype;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 9) < 7) begin
            append_byte(BYTE_ESC);
            append_byte(BYTE_LBRACK);
            // An empty parameter list now and then.
            if ($urandom_range(0, 19) != 0) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: cmd = CMD_FG;
                  4, 5, 6, 7: cmd = CMD_BG;
                  8:          cmd = $urandom_range(0, 99);
                  default:    cmd = $urandom_range(65530, 99999);
               endcase
               queue_field(cmd);
               append_byte(BYTE_SEMI);
               ctype = ($urandom_range(0, 4) != 0) ? COLOR_INDEX : $urandom_range(0, 65600);
               queue_field(ctype);
               if ($urandom_range(0, 9) != 0) begin
                  append_byte(BYTE_SEMI);
                  if ($urandom_range(0, 9) != 0)
                     queue_field(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99999)
                                                             : $urandom_range(0, 255));
               end
               // Fields past the palette are ignored by the block.
               if ($urandom_range(0, 5) == 0)
                  repeat ($urandom_range(1, 3)) begin
                     append_byte(BYTE_SEMI);
                     queue_field($urandom_range(0, 255));
                  end
            end
            append_byte(($urandom_range(0, 6) != 0) ? BYTE_M
                        : 8'($urandom_range(FINAL_LO, FINAL_HI)));
         end else begin
            repeat ($urandom_range(1, 6))
               case ($urandom_range(0, 5))
                  0:       append_byte(BYTE_ESC);
                  1:       append_byte(param_junk());
                  2:       append_byte(BYTE_LBRACK);
                  default: append_byte(8'($urandom_range(0, 255)));
               endcase
         end
         send_queued_bytes();
      end
   endtask

   // The sender stops mid-sequence until every owed result has drained.
   task automatic test_drain_pause();
      send_byte(BYTE_ESC);
      send_text("[48;");
      wait_idle();
      send_text("5;7m");
   endtask

   // Random traffic, escapes included, with decoding off.
   task automatic test_bypass_traffic(input int target);
      write_decode_enable(1'b0);
      test_mixed_traffic(target);
      write_decode_enable(1'b1);
   endtask

   // Back-to-back bytes with no sender gaps.
   task automatic test_steady_traffic(input int target);
      steady_sender = 1'b1;
      test_mixed_traffic(target);
      steady_sender = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side. The ready follows one of several patterns for a random
   // number of cycles: always ready, coin flips, mostly stalled, or a fixed
   // two-of-seven duty cycle.
   // ---------------------------------------------------------------------
   int rx_mode  = 0;
   int rx_left  = 0;
   int rx_phase = 0;

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(20, 200);
      end else begin
         rx_left--;
      end
      rx_phase = (rx_phase + 1) % 7;
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (rx_phase < 2);
      endcase
   end

   // Every accepted result is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 20)
               $display("%0t: unexpected result kind=%0d value=%02h last=%0b",
                        $realtime, rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.kind != KIND_CHAR)
               palette_cmds++;
            if (rsp_tuser !== want.kind || rsp_tdata !== want.value ||
                rsp_tlast !== want.last) begin
               error_count++;
               if (error_count <= 20)
                  $display(
                     "%0t: expected kind=%0d value=%02h last=%0b, got kind=%0d value=%02h last=%0b",
                     $realtime, want.kind, want.value, want.last,
                     rsp_tuser, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_decode_enable(1'b1);

      test_text_and_escapes();
      test_palette_commands();
      test_decode_disable();
      test_mixed_traffic(500);
      test_drain_pause();
      test_mixed_traffic(700);
      test_bypass_traffic(850);
      test_steady_traffic(950);
      test_mixed_traffic(1050);

      // Let the last results drain, then wait on for stragglers.
      req_tvalid <= 1'b0;
      for (int i = 0; i < 5000 && pending_results.size() != 0; i++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived",
                  $realtime, pending_results.size());
      end

      $display("Sent %0d bytes through %0d decode-enable writes;",
               bytes_sent, cfg_writes);
      $display("checked %0d result items, %0d of them palette commands.",
               results_checked, palette_cmds);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
